// ===== src/brc_pkg.sv =====
// Shared types and constants for the block-raster YCbCr-to-RGB unit.
`default_nettype none

package brc_pkg;

  // Side of one square sample block, in pixels.
  localparam int BLOCK_SIDE = 8;

  // Configuration port geometry and register indexes.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE   = 2'd2;

  // Register values after reset.
  localparam logic [15:0] IMAGE_WIDTH_RST  = 16'd8;
  localparam logic [15:0] IMAGE_HEIGHT_RST = 16'd8;
  localparam logic        COLOR_MODE_RST   = 1'b1;

  // Fixed-point color conversion constants (17 fractional bits).
  localparam int FRAC_BITS = 17;
  localparam logic [17:0] COEF_R_CR = 18'd183763;
  localparam logic [17:0] COEF_G_CB = 18'd45107;
  localparam logic [17:0] COEF_G_CR = 18'd93604;
  localparam logic [17:0] COEF_B_CB = 18'd232260;
  localparam logic [8:0]  CHROMA_BIAS = 9'd128;
  localparam logic [7:0]  PIX_MAX = 8'd255;

  // Width of the signed intermediate sums.
  localparam int SUM_W = 28;

  // One input sample triple.
  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
  } in_item_t;

  // One result pixel with the next scan address.
  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [25:0] next_block;
    logic [5:0]  next_sample;
    logic        last_pixel;
  } out_item_t;

  // Work handed from the scan front end to the color back end.
  typedef struct packed {
    in_item_t    sample;
    logic        color_mode;
    logic [25:0] next_block;
    logic [5:0]  next_sample;
    logic        last_pixel;
  } job_t;

endpackage

`default_nettype wire

// ===== src/brc_front.sv =====
// Scan front end: configuration registers, block-raster address walk, job issue.
`default_nettype none

module brc_front (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            cfg_we,
  input  wire  [brc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [brc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire                            in_push,
  input  brc_pkg::in_item_t              in_data,
  input  wire                            q_full,
  output logic                           q_push,
  output brc_pkg::job_t                  q_data
);
  import brc_pkg::*;

  localparam logic [2:0]  CIB_LAST = 3'(BLOCK_SIDE - 1);
  localparam logic [15:0] COL_STEP = 16'(BLOCK_SIDE);

  logic [15:0] image_width_r, image_height_r;
  logic        color_mode_r;

  logic [15:0] col_pix_r, col_pix_nxt;
  logic [2:0]  cib_r, cib_nxt;
  logic [2:0]  rib_r, rib_nxt;
  logic [12:0] bir_r, bir_nxt;
  logic [25:0] rbb_r, rbb_nxt;
  logic [15:0] rows_r, rows_nxt;

  logic [16:0] x_plus1;
  logic [16:0] rows_plus1;
  logic        row_end, img_end;
  logic [25:0] blocks;

  // Configuration writes; an index beyond the list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= IMAGE_WIDTH_RST;
      image_height_r <= IMAGE_HEIGHT_RST;
      color_mode_r   <= COLOR_MODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata[15:0];
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_wdata[15:0];
        CFG_COLOR_MODE:   color_mode_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign q_push = in_push && !q_full;

  // Row and image end detection.
  assign x_plus1    = {1'b0, col_pix_r} + {14'd0, cib_r} + 17'd1;
  assign rows_plus1 = {1'b0, rows_r} + 17'd1;
  assign row_end    = x_plus1 >= {1'b0, image_width_r};
  assign img_end    = row_end && (rows_plus1 >= {1'b0, image_height_r});
  assign blocks     = {13'd0, bir_r} + 26'd1;

  // Next scan position.
  always_comb begin
    col_pix_nxt = col_pix_r;
    cib_nxt     = cib_r;
    rib_nxt     = rib_r;
    bir_nxt     = bir_r;
    rbb_nxt     = rbb_r;
    rows_nxt    = rows_r;
    if (row_end) begin
      col_pix_nxt = '0;
      cib_nxt     = '0;
      bir_nxt     = '0;
      if (img_end) begin
        rib_nxt  = '0;
        rbb_nxt  = '0;
        rows_nxt = '0;
      end else begin
        rows_nxt = rows_plus1[15:0];
        if (rib_r == CIB_LAST) begin
          rbb_nxt = rbb_r + blocks;
          rib_nxt = '0;
        end else begin
          rib_nxt = rib_r + 3'd1;
        end
      end
    end else if (cib_r == CIB_LAST) begin
      col_pix_nxt = col_pix_r + COL_STEP;
      cib_nxt     = '0;
      bir_nxt     = bir_r + 13'd1;
    end else begin
      cib_nxt = cib_r + 3'd1;
    end
  end

  // Scan state advances once per transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pix_r <= '0;
      cib_r     <= '0;
      rib_r     <= '0;
      bir_r     <= '0;
      rbb_r     <= '0;
      rows_r    <= '0;
    end else if (q_push) begin
      col_pix_r <= col_pix_nxt;
      cib_r     <= cib_nxt;
      rib_r     <= rib_nxt;
      bir_r     <= bir_nxt;
      rbb_r     <= rbb_nxt;
      rows_r    <= rows_nxt;
    end
  end

  // Job for the back end: the samples plus the address after this step.
  always_comb begin
    q_data.sample      = in_data;
    q_data.color_mode  = color_mode_r;
    q_data.next_block  = rbb_nxt + {13'd0, bir_nxt};
    q_data.next_sample = {rib_nxt, cib_nxt};
    q_data.last_pixel  = img_end;
  end

endmodule

`default_nettype wire

// ===== src/brc_queue.sv =====
// Short job queue between the scan front end and the color back end.
`default_nettype none

module brc_queue #(
  parameter int DEPTH = 4
) (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            push,
  input  brc_pkg::job_t  push_data,
  output logic           full,
  input  wire            pop,
  output brc_pkg::job_t  pop_data,
  output logic           empty
);
  import brc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full     = count_r == CNT_FULL;
  assign empty    = count_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/brc_back.sv =====
// Color back end: multiply stage, then sum and clamp into the output register.
`default_nettype none

module brc_back (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               q_empty,
  input  brc_pkg::job_t     q_data,
  output logic              q_pop,
  output logic              out_empty,
  input  wire               out_pop,
  output brc_pkg::out_item_t out_data
);
  import brc_pkg::*;

  // Coefficients widened to the sum width so the products cannot overflow.
  localparam logic signed [SUM_W-1:0] K_R_CR = {{(SUM_W-18){1'b0}}, COEF_R_CR};
  localparam logic signed [SUM_W-1:0] K_G_CB = {{(SUM_W-18){1'b0}}, COEF_G_CB};
  localparam logic signed [SUM_W-1:0] K_G_CR = {{(SUM_W-18){1'b0}}, COEF_G_CR};
  localparam logic signed [SUM_W-1:0] K_B_CB = {{(SUM_W-18){1'b0}}, COEF_B_CB};

  // Clamp a scaled channel to 0..255 after dropping the fraction.
  function automatic logic [7:0] clamp_channel(input logic signed [SUM_W-1:0] v);
    logic [7:0] q;
    if (v[SUM_W-1]) begin
      q = '0;
    end else if (|v[SUM_W-2:FRAC_BITS+8]) begin
      q = PIX_MAX;
    end else begin
      q = v[FRAC_BITS+7:FRAC_BITS];
    end
    return q;
  endfunction

  // Multiply stage registers.
  logic                    s1_v_r;
  logic                    s1_mode_r;
  logic [7:0]              s1_y_r;
  logic signed [SUM_W-1:0] s1_r_cr_r, s1_g_cb_r, s1_g_cr_r, s1_b_cb_r;
  logic [25:0]             s1_block_r;
  logic [5:0]              s1_sample_r;
  logic                    s1_last_r;

  // Output register.
  logic      out_v_r;
  out_item_t out_data_r;

  logic                    out_ready, s1_ready;
  logic signed [8:0]       cb_s, cr_s;
  logic signed [SUM_W-1:0] cb_x, cr_x;
  logic signed [SUM_W-1:0] base;
  out_item_t               out_nxt;

  // Elastic handshake: each stage advances when the one after it has room.
  assign out_ready = !out_v_r || out_pop;
  assign s1_ready  = !s1_v_r || out_ready;
  assign q_pop     = !q_empty && s1_ready;
  assign out_empty = !out_v_r;
  assign out_data  = out_data_r;

  // Centered chroma, sign-extended to the sum width.
  assign cb_s = $signed({1'b0, q_data.sample.chroma_blue} - CHROMA_BIAS);
  assign cr_s = $signed({1'b0, q_data.sample.chroma_red} - CHROMA_BIAS);
  assign cb_x = {{(SUM_W-9){cb_s[8]}}, cb_s};
  assign cr_x = {{(SUM_W-9){cr_s[8]}}, cr_s};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_ready) begin
      s1_v_r <= q_pop;
    end
  end

  // Constant products per job.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_mode_r   <= q_data.color_mode;
      s1_y_r      <= q_data.sample.luma;
      s1_r_cr_r   <= K_R_CR * cr_x;
      s1_g_cb_r   <= K_G_CB * cb_x;
      s1_g_cr_r   <= K_G_CR * cr_x;
      s1_b_cb_r   <= K_B_CB * cb_x;
      s1_block_r  <= q_data.next_block;
      s1_sample_r <= q_data.next_sample;
      s1_last_r   <= q_data.last_pixel;
    end
  end

  // Sum, clamp and gray-mode bypass.
  assign base = $signed({{(SUM_W-8-FRAC_BITS){1'b0}}, s1_y_r, {FRAC_BITS{1'b0}}});

  always_comb begin
    out_nxt.next_block  = s1_block_r;
    out_nxt.next_sample = s1_sample_r;
    out_nxt.last_pixel  = s1_last_r;
    if (s1_mode_r) begin
      out_nxt.red   = clamp_channel(base + s1_r_cr_r);
      out_nxt.green = clamp_channel(base - s1_g_cb_r - s1_g_cr_r);
      out_nxt.blue  = clamp_channel(base + s1_b_cb_r);
    end else begin
      out_nxt.red   = s1_y_r;
      out_nxt.green = s1_y_r;
      out_nxt.blue  = s1_y_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_ready) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s1_v_r) begin
      out_data_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/block_raster_ycbcr_to_rgb_unit.sv =====
// Top level of the block-raster YCbCr-to-RGB unit.
`default_nettype none

// Walks an image stored as 8x8 sample blocks in pixel raster order. Each
// transfer in carries the Y, Cb and Cr samples found at the current scan
// address; each transfer out carries one pixel (converted to RGB, or luma on
// all three channels in gray mode), the block number and sample offset to
// read next, and a flag on the image's final pixel, after which the scan
// restarts at block 0, sample 0. One pixel is accepted per clock while the
// queue has room: the front end updates its scan address on each transfer,
// and the color back end is a two-stage pipeline (constant multiply, then
// sum and clamp) that takes one job per clock while its output is free. A
// result passes the short queue, the multiply stage and the output register
// in turn; the queue absorbs output stalls. The user must write registers
// (width, height, color mode) only while idle; the unit does not enforce it.
module block_raster_ycbcr_to_rgb_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            cfg_we,
  input  wire  [brc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [brc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire                            in_push,
  input  brc_pkg::in_item_t              in_data,
  output logic                           in_full,
  output logic                           out_empty,
  input  wire                            out_pop,
  output brc_pkg::out_item_t             out_data
);
  import brc_pkg::*;

  logic q_push, q_pop, q_full, q_empty;
  job_t q_wdata, q_rdata;

  assign in_full = q_full;

  // Scan walk and job issue.
  brc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  // Decoupling queue.
  brc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // Color conversion and output register.
  brc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  // The final pixel always points the next read back at the image start.
  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.last_pixel) |->
      (out_data.next_block == '0 && out_data.next_sample == '0))
    else $error("last pixel does not return the scan to the start");

  // An accepted transfer leaves at least one job in the queue.
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> !q_empty)
    else $error("accepted input did not reach the job queue");

  // Leaving reset, the unit is empty and ready for input.
  a_reset_clean: assert property (@(posedge clk)
    $rose(rst_n) |-> (!in_full && out_empty && q_empty))
    else $error("unit not empty after reset");

endmodule

`default_nettype wire

// ===== verif/block_raster_ycbcr_to_rgb_unit_test.sv =====
// Self-checking testbench for the block-raster YCbCr-to-RGB unit.
`timescale 1ns / 100ps

module block_raster_ycbcr_to_rgb_unit_test;
  import brc_pkg::*;

  // Fixed-point color coefficients, 17 fractional bits.
  localparam int R_FROM_CR = 183763;
  localparam int G_FROM_CB = 45107;
  localparam int G_FROM_CR = 93604;
  localparam int B_FROM_CB = 232260;
  localparam int ONE_Q17   = 131072;
  localparam int Q_SHIFT   = 17;

  // An index past the last register; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_LIMIT = 10;

  // Traffic shaping for one phase of the run.
  typedef enum logic [1:0] {
    PACE_FULL,
    PACE_SEND_GAPS,
    PACE_RECV_STALLS,
    PACE_BOTH
  } pace_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic               in_push;
  in_item_t           in_data;
  logic               in_full;
  logic               out_empty;
  logic               out_pop;
  out_item_t          out_data;

  // Register shadow used by the pixel predictor.
  logic [15:0] img_width;
  logic [15:0] img_height;
  logic        color_on;

  // Scan position of the predictor.
  logic [15:0] col_px;
  logic [2:0]  col_in_blk;
  logic [2:0]  row_in_blk;
  logic [12:0] blk_in_row;
  logic [25:0] row_base;
  logic [15:0] rows_done;

  in_item_t  samples_to_send[$];
  out_item_t pixels_due[$];
  pace_t     pace;
  int        mismatch_count;
  int        pixel_count;
  int        quiet_cycles;

  block_raster_ycbcr_to_rgb_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  // Free-running 10 ns clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Floor of a Q17 value, clamped to one byte.
  function automatic logic [7:0] clamp_to_byte(input int v);
    int q;
    if (v < 0) begin
      return 8'd0;
    end
    q = v >>> Q_SHIFT;
    return (q > 255) ? 8'd255 : 8'(q);
  endfunction

  // Converts one sample triple and advances the scan to the next read address.
  function automatic out_item_t raster_step(input in_item_t s);
    out_item_t   o;
    int          y;
    int          cb;
    int          cr;
    int          base;
    logic [25:0] blocks;
    o = '0;
    y = int'(s.luma);
    cb = int'(s.chroma_blue) - 128;
    cr = int'(s.chroma_red) - 128;
    base = y * ONE_Q17;
    if (color_on) begin
      o.red   = clamp_to_byte(base + R_FROM_CR * cr);
      o.green = clamp_to_byte(base - G_FROM_CB * cb - G_FROM_CR * cr);
      o.blue  = clamp_to_byte(base + B_FROM_CB * cb);
    end else begin
      o.red   = s.luma;
      o.green = s.luma;
      o.blue  = s.luma;
    end

    // The row ends once the column reaches the width, even if it is already past it.
    if (int'(col_px) + int'(col_in_blk) + 1 >= int'(img_width)) begin
      blocks = 26'(blk_in_row) + 26'd1;
      col_px = '0;
      col_in_blk = '0;
      blk_in_row = '0;
      if (int'(rows_done) + 1 >= int'(img_height)) begin
        o.last_pixel = 1'b1;
        row_in_blk = '0;
        row_base = '0;
        rows_done = '0;
      end else begin
        rows_done = rows_done + 16'd1;
        if (row_in_blk == 3'(BLOCK_SIDE - 1)) begin
          row_base = row_base + blocks;
          row_in_blk = '0;
        end else begin
          row_in_blk = row_in_blk + 3'd1;
        end
      end
    end else if (col_in_blk == 3'(BLOCK_SIDE - 1)) begin
      col_px = col_px + 16'(BLOCK_SIDE);
      col_in_blk = '0;
      blk_in_row = blk_in_row + 13'd1;
    end else begin
      col_in_blk = col_in_blk + 3'd1;
    end

    o.next_block = row_base + 26'(blk_in_row);
    o.next_sample = {row_in_blk, col_in_blk};
    return o;
  endfunction

  function automatic logic sender_waits();
    case (pace)
      PACE_SEND_GAPS: return $urandom_range(99) < 56;
      PACE_BOTH:      return $urandom_range(99) < 19;
      default:        return 1'b0;
    endcase
  endfunction

  function automatic logic receiver_waits();
    case (pace)
      PACE_RECV_STALLS: return $urandom_range(99) < 56;
      PACE_BOTH:        return $urandom_range(99) < 19;
      default:          return 1'b0;
    endcase
  endfunction

  function automatic in_item_t random_sample();
    in_item_t s;
    s.luma = 8'($urandom);
    s.chroma_blue = 8'($urandom);
    s.chroma_red = 8'($urandom);
    return s;
  endfunction

  // Driver: predicts each accepted transfer and offers the next pending sample.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        pixels_due.push_back(raster_step(in_data));
      end
      if (in_push && in_full) begin
        // Hold the offered sample until it is taken.
      end else if (samples_to_send.size() > 0 && !sender_waits()) begin
        in_push <= 1'b1;
        in_data <= samples_to_send.pop_front();
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // Monitor: checks each result transfer against the oldest predicted pixel.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        pixel_count++;
        if (pixels_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("Unexpected pixel %0d: rgb %0d %0d %0d blk %0d smp %0d last %0d",
                     pixel_count, out_data.red, out_data.green, out_data.blue,
                     out_data.next_block, out_data.next_sample, out_data.last_pixel);
          end
        end else begin
          want = pixels_due.pop_front();
          if (out_data.red !== want.red || out_data.green !== want.green ||
              out_data.blue !== want.blue || out_data.next_block !== want.next_block ||
              out_data.next_sample !== want.next_sample ||
              out_data.last_pixel !== want.last_pixel) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
              $display("Pixel %0d mismatch: got rgb %0d %0d %0d blk %0d smp %0d last %0d",
                       pixel_count, out_data.red, out_data.green, out_data.blue,
                       out_data.next_block, out_data.next_sample, out_data.last_pixel);
              $display("  expected rgb %0d %0d %0d blk %0d smp %0d last %0d",
                       want.red, want.green, want.blue,
                       want.next_block, want.next_sample, want.last_pixel);
            end
          end
        end
      end
      out_pop <= !receiver_waits();
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL block_raster_ycbcr_to_rgb_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One register write; the predictor's copy is updated at the same edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_IMAGE_WIDTH:  img_width = value;
      CFG_IMAGE_HEIGHT: img_height = value;
      CFG_COLOR_MODE:   color_on = value[0];
      default: ;
    endcase
  endtask

  // Waits until all samples are taken and all pixels are back, then lets the pipe settle.
  task automatic wait_until_idle();
    @(negedge clk);
    while (samples_to_send.size() > 0 || pixels_due.size() > 0 || in_push) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input logic [15:0] w, input logic [15:0] h, input logic c,
                           input int count, input pace_t p);
    wait_until_idle();
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_COLOR_MODE, {15'd0, c});
    @(negedge clk);
    pace = p;
    repeat (count) samples_to_send.push_back(random_sample());
  endtask

  // Stimulus sequence.
  initial begin
    in_item_t s;
    logic [7:0] corners[16][3];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_push = 1'b0;
    in_data = '0;
    out_pop = 1'b0;
    mismatch_count = 0;
    pixel_count = 0;
    quiet_cycles = 0;
    pace = PACE_FULL;
    img_width = IMAGE_WIDTH_RST;
    img_height = IMAGE_HEIGHT_RST;
    color_on = COLOR_MODE_RST;
    col_px = '0;
    col_in_blk = '0;
    row_in_blk = '0;
    blk_in_row = '0;
    row_base = '0;
    rows_done = '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Extreme and saturating triples under the reset settings (8x8, color).
    corners = '{'{8'd0, 8'd128, 8'd128}, '{8'd255, 8'd128, 8'd128},
                '{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255},
                '{8'd0, 8'd255, 8'd255}, '{8'd255, 8'd0, 8'd0},
                '{8'd128, 8'd0, 8'd255}, '{8'd128, 8'd255, 8'd0},
                '{8'd0, 8'd0, 8'd255}, '{8'd255, 8'd255, 8'd0},
                '{8'd16, 8'd128, 8'd128}, '{8'd235, 8'd240, 8'd16},
                '{8'd81, 8'd90, 8'd240}, '{8'd145, 8'd54, 8'd34},
                '{8'd41, 8'd240, 8'd110}, '{8'd170, 8'd166, 8'd16}};
    @(negedge clk);
    foreach (corners[i]) begin
      s.luma = corners[i][0];
      s.chroma_blue = corners[i][1];
      s.chroma_red = corners[i][2];
      samples_to_send.push_back(s);
    end

    // Gray mode on a tiny image: row ends and the last-pixel wrap.
    wait_until_idle();
    write_reg(CFG_IMAGE_WIDTH, 16'd3);
    write_reg(CFG_IMAGE_HEIGHT, 16'd2);
    write_reg(CFG_COLOR_MODE, 16'd0);
    @(negedge clk);
    for (int i = 0; i < 8; i++) begin
      s.luma = (i % 2 == 0) ? 8'd255 : 8'd0;
      s.chroma_blue = 8'($urandom);
      s.chroma_red = 8'($urandom);
      samples_to_send.push_back(s);
    end

    // Random phases: zero sizes, one pixel, full images, the largest sizes.
    run_phase(16'd0, 16'd5, 1'b1, 30, PACE_FULL);
    run_phase(16'd6, 16'd0, 1'b0, 30, PACE_RECV_STALLS);
    run_phase(16'd1, 16'd1, 1'b1, 30, PACE_SEND_GAPS);
    run_phase(16'd20, 16'd11, 1'b1, 240, PACE_SEND_GAPS);
    run_phase(16'hFFFF, 16'hFFFF, 1'b1, 60, PACE_RECV_STALLS);
    run_phase(16'd9, 16'd17, 1'b0, 160, PACE_BOTH);

    // A write past the register list must change nothing.
    wait_until_idle();
    write_reg(CFG_SPARE_IDX, 16'($urandom));

    // Width lowered mid-scan, so the current column may already lie past it.
    run_phase(16'd4, 16'd3, 1'b1, 80, PACE_FULL);
    for (int i = 0; i < 4; i++) begin
      run_phase(16'($urandom_range(24, 1)), 16'($urandom_range(12, 1)), 1'($urandom),
                55, pace_t'($urandom_range(3)));
    end

    wait_until_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && pixels_due.size() == 0) begin
      $display("PASS block_raster_ycbcr_to_rgb_unit");
    end else begin
      $display("FAIL block_raster_ycbcr_to_rgb_unit");
    end
    $finish;
  end

endmodule
